// ===== src/bpc_pkg.sv =====
// shared types, constants and helpers for the button press classifier
package bpc_pkg;

    // counter width for the press and release tick counters
    localparam int COUNT_BITS = 16;
    localparam int THR_BITS   = 16;
    localparam int CMP_BITS   = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
    localparam int TICK_BITS  = 8;
    localparam int DUR_BITS   = COUNT_BITS + TICK_BITS;
    localparam int SHORT_BITS = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SHORT_BITS-1:0] SHORT_MAX = {SHORT_BITS{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESS_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_UNIT     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_WAIT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_TIME    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_TIME     = 3'd6;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PRESS = 2'd1,
        PH_SHORT = 2'd2,
        PH_LONG  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    typedef struct packed {
        logic                  enable;
        logic                  press_level;
        logic [TICK_BITS-1:0]  tick_unit;
        logic [THR_BITS-1:0]   debounce_ticks;
        logic [THR_BITS-1:0]   release_wait_ticks;
        logic [THR_BITS-1:0]   short_thr;
        logic [THR_BITS-1:0]   long_thr;
    } cfg_t;

    typedef struct packed {
        event_t                ev;
        phase_t                phase;
        logic                  pressed;
        logic [SHORT_BITS-1:0] short_count;
    } res_t;

    // count reaches a 16-bit threshold
    function automatic logic cnt_ge(input logic [COUNT_BITS-1:0] cnt,
                                    input logic [THR_BITS-1:0] thr);
        return CMP_BITS'(cnt) >= CMP_BITS'(thr);
    endfunction

    // saturating increment of a tick counter
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cnt);
        return (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
    endfunction

endpackage

// ===== src/button_press_classifier_unit.sv =====
// top level of the button press classifier: input stage, core and result register
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, level                 | into block
//  out     | out_valid, out_stall, event_res, phase,   | out of block
//          | pressed, short_count                      |
//  cfg     | cfg_we, cfg_index, cfg_data               | into block
//
// one word per clock sustained while out_stall is low; a sample is held in the input register,
// then its result is held in the result register until it can leave.
// the state update is a single pass through the counters, a 16x8-bit
// duration multiply and the phase machine between those two registers.
// reset is asynchronous; valid, config and state registers come up with their defaults, data registers are not reset.
// a stalled result holds and the input stage stalls only when it is full too.
module button_press_classifier_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          event_res,
    output logic [1:0]                          phase,
    output logic                                pressed,
    output logic [bpc_pkg::SHORT_BITS-1:0]      short_count,
    input  logic                                cfg_we,
    input  logic [bpc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [bpc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    bpc_pkg::cfg_t  cfg;
    bpc_pkg::res_t  res;
    bpc_pkg::res_t  res_reg;
    logic           s1_valid_reg;
    logic           level_reg;
    logic           out_valid_reg;
    logic           out_free;
    logic           s1_adv;
    logic           in_fire;

    bpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (s1_adv),
        .level (level_reg),
        .res   (res)
    );

    // handshake between the two stages
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            level_reg <= level;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = res_reg.ev;
    assign phase       = res_reg.phase;
    assign pressed     = res_reg.pressed;
    assign short_count = res_reg.short_count;

endmodule

// ===== src/bpc_cfg_regs.sv =====
// configuration register bank for the button press classifier
module bpc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bpc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [bpc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output bpc_pkg::cfg_t                       cfg
);

    bpc_pkg::cfg_t cfg_reg;
    bpc_pkg::cfg_t cfg_next;

    // decode one register write, wider data masked to the register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bpc_pkg::CFG_ENABLE:       cfg_next.enable = cfg_data[0];
                bpc_pkg::CFG_PRESS_LEVEL:  cfg_next.press_level = cfg_data[0];
                bpc_pkg::CFG_TICK_UNIT:
                    cfg_next.tick_unit = cfg_data[bpc_pkg::TICK_BITS-1:0];
                bpc_pkg::CFG_DEBOUNCE:
                    cfg_next.debounce_ticks = cfg_data[bpc_pkg::THR_BITS-1:0];
                bpc_pkg::CFG_RELEASE_WAIT:
                    cfg_next.release_wait_ticks = cfg_data[bpc_pkg::THR_BITS-1:0];
                bpc_pkg::CFG_SHORT_TIME:
                    cfg_next.short_thr = cfg_data[bpc_pkg::THR_BITS-1:0];
                bpc_pkg::CFG_LONG_TIME:
                    cfg_next.long_thr = cfg_data[bpc_pkg::THR_BITS-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank with its reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable             <= 1'b1;
            cfg_reg.press_level        <= 1'b1;
            cfg_reg.tick_unit          <= bpc_pkg::TICK_BITS'(1);
            cfg_reg.debounce_ticks     <= bpc_pkg::THR_BITS'(2);
            cfg_reg.release_wait_ticks <= bpc_pkg::THR_BITS'(30);
            cfg_reg.short_thr          <= bpc_pkg::THR_BITS'(50);
            cfg_reg.long_thr           <= bpc_pkg::THR_BITS'(2200);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/bpc_core.sv =====
// debounce counters and press phase machine, one level sample per step
module bpc_core (
    input  logic            clk,
    input  logic            rst_n,
    input  bpc_pkg::cfg_t   cfg,
    input  logic            step,
    input  logic            level,
    output bpc_pkg::res_t   res
);

    logic                               last_level_reg, last_level_next;
    logic [bpc_pkg::COUNT_BITS-1:0]     press_cnt_reg, press_cnt_next;
    logic [bpc_pkg::COUNT_BITS-1:0]     release_cnt_reg, release_cnt_next;
    logic                               pressed_reg, pressed_next;
    bpc_pkg::phase_t                    phase_reg, phase_next;
    logic                               resume_reg, resume_next;
    logic [bpc_pkg::SHORT_BITS-1:0]     short_cnt_reg, short_cnt_next;
    bpc_pkg::event_t                    ev_next;
    logic [bpc_pkg::DUR_BITS-1:0]       dur;

    // counter update then phase decision for the sampled level
    always_comb
    begin
        last_level_next  = last_level_reg;
        press_cnt_next   = press_cnt_reg;
        release_cnt_next = release_cnt_reg;
        pressed_next     = pressed_reg;
        phase_next       = phase_reg;
        resume_next      = resume_reg;
        short_cnt_next   = short_cnt_reg;
        ev_next          = bpc_pkg::EV_NONE;
        dur              = '0;

        if (cfg.enable)
        begin
            // level change restarts the release count, and the press count on a new press
            if (level != last_level_reg)
            begin
                if (level == cfg.press_level)
                begin
                    press_cnt_next = '0;
                end
                last_level_next  = level;
                release_cnt_next = '0;
            end
            else if (last_level_reg == cfg.press_level)
            begin
                press_cnt_next = bpc_pkg::sat_inc(press_cnt_reg);
                if (bpc_pkg::cnt_ge(press_cnt_next, cfg.debounce_ticks))
                begin
                    pressed_next = 1'b1;
                end
            end
            else
            begin
                release_cnt_next = bpc_pkg::sat_inc(release_cnt_reg);
                if (bpc_pkg::cnt_ge(release_cnt_next, cfg.release_wait_ticks))
                begin
                    pressed_next     = 1'b0;
                    press_cnt_next   = '0;
                    release_cnt_next = '0;
                    phase_next       = bpc_pkg::PH_IDLE;
                    short_cnt_next   = '0;
                end
            end

            dur = bpc_pkg::DUR_BITS'(press_cnt_next)
                * bpc_pkg::DUR_BITS'(cfg.tick_unit);

            // resume tick clears the counters, press flag, phase and short count, otherwise advance the phase
            if (resume_reg)
            begin
                resume_next      = 1'b0;
                pressed_next     = 1'b0;
                press_cnt_next   = '0;
                release_cnt_next = '0;
                phase_next       = bpc_pkg::PH_IDLE;
                short_cnt_next   = '0;
            end
            else
            begin
                // phase as left by the counter update, idle after a release timeout
                case (phase_next)
                    bpc_pkg::PH_IDLE:
                    begin
                        if (pressed_next)
                        begin
                            phase_next = bpc_pkg::PH_PRESS;
                        end
                    end
                    bpc_pkg::PH_PRESS:
                    begin
                        if ((dur >= bpc_pkg::DUR_BITS'(cfg.short_thr))
                            && (last_level_next != cfg.press_level)
                            && bpc_pkg::cnt_ge(release_cnt_next, cfg.debounce_ticks))
                        begin
                            phase_next = bpc_pkg::PH_SHORT;
                            if (short_cnt_next != bpc_pkg::SHORT_MAX)
                            begin
                                short_cnt_next = short_cnt_next + 1'b1;
                            end
                        end
                        // long press test comes last and wins
                        if (dur >= bpc_pkg::DUR_BITS'(cfg.long_thr))
                        begin
                            phase_next = bpc_pkg::PH_LONG;
                        end
                    end
                    bpc_pkg::PH_SHORT:
                    begin
                        if (short_cnt_next != bpc_pkg::SHORT_MAX)
                        begin
                            short_cnt_next = short_cnt_next + 1'b1;
                        end
                        if (bpc_pkg::cnt_ge(release_cnt_next, cfg.debounce_ticks))
                        begin
                            phase_next  = bpc_pkg::PH_IDLE;
                            resume_next = 1'b1;
                            ev_next     = bpc_pkg::EV_SHORT;
                        end
                    end
                    default:
                    begin
                        phase_next  = bpc_pkg::PH_IDLE;
                        resume_next = 1'b1;
                        ev_next     = bpc_pkg::EV_LONG;
                    end
                endcase
            end
        end
    end

    // classifier state, updated once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg  <= 1'b0;
            press_cnt_reg   <= '0;
            release_cnt_reg <= '0;
            pressed_reg     <= 1'b0;
            phase_reg       <= bpc_pkg::PH_IDLE;
            resume_reg      <= 1'b0;
            short_cnt_reg   <= '0;
        end
        else if (step)
        begin
            last_level_reg  <= last_level_next;
            press_cnt_reg   <= press_cnt_next;
            release_cnt_reg <= release_cnt_next;
            pressed_reg     <= pressed_next;
            phase_reg       <= phase_next;
            resume_reg      <= resume_next;
            short_cnt_reg   <= short_cnt_next;
        end
    end

    // result word shows the state after this sample
    assign res.ev          = ev_next;
    assign res.phase       = phase_next;
    assign res.pressed     = pressed_next;
    assign res.short_count = short_cnt_next;

endmodule
